// File: rtl/scbd_pkg.sv
// Shared constants and types for the shift-capture button debouncer.
package scbd_pkg;

  localparam int NumButtons = 16;
  localparam int WordW      = 16;
  localparam int TimeW      = 32;
  localparam int ThrW       = 16;
  localparam int BitIdxW    = $clog2(WordW);
  localparam int BtnIdxW    = (NumButtons > 1) ? $clog2(NumButtons) : 1;

  localparam int InDataW    = 56;  // 1 + 16 + 32 bits, padded to whole bytes
  localparam int OutDataW   = 40;  // 16 + 16 + 1 + 1 bits, padded to whole bytes

  // Configuration register indexes
  localparam logic CfgDebounceTime   = 1'b0;
  localparam logic CfgDebounceEnable = 1'b1;

  localparam logic [ThrW-1:0] DebounceTimeReset = ThrW'(30);

  // Write request into the per-button timestamp store
  typedef struct packed {
    logic               en;
    logic [BtnIdxW-1:0] addr;
    logic [TimeW-1:0]   data;
  } scbd_wr_t;

endpackage

// File: rtl/scbd_time_store.sv
// Per-button last-change timestamps, cleared to zero on reset.
module scbd_time_store
  import scbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  scbd_wr_t           wr,
  input  logic [BtnIdxW-1:0] raddr,
  output logic [TimeW-1:0]   rdata
);

  logic [TimeW-1:0] stamp [NumButtons];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumButtons; i++) begin
        stamp[i] <= '0;
      end
    end else if (wr.en) begin
      stamp[wr.addr] <= wr.data;
    end
  end

  assign rdata = stamp[raddr];

endmodule

// File: rtl/scbd_elapsed_cmp.sv
// Shared elapsed-time unit: (now - last) mod 2^32 compared against the threshold.
module scbd_elapsed_cmp
  import scbd_pkg::*;
(
  input  logic [TimeW-1:0] now_ms,
  input  logic [TimeW-1:0] last_ms,
  input  logic [ThrW-1:0]  thr_ms,
  output logic             expired
);

  logic [TimeW-1:0] elapsed;

  assign elapsed = now_ms - last_ms;
  assign expired = elapsed >= TimeW'(thr_ms);

endmodule

// File: rtl/shift_capture_button_debouncer_unit.sv
// Top level of the shift-capture button debouncer: sequencer, config and stream ports.
//
// One poll is taken when s_tready is high, then the buttons are walked one per
// clock through a single shared subtract/compare unit before the result is
// offered on the master side; in bypass mode the result is offered in the
// cycle after accept. The input side stays closed from accept until the
// result transfer completes. Button words are active low with button 1 at
// bit 15. The per-button timestamp store is cleared by reset, so no
// clearing pass is needed.
module shift_capture_button_debouncer_unit
  import scbd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // slave side
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // first_bit[0], shifted_word[16:1], now_ms[48:17]
  // master side
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // raw_buttons[15:0], stable_buttons[31:16],
                                         // stable_changed[32], any_pressed[33]
  // configuration
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [ThrW-1:0]     cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_t;

  state_t              state;
  logic [BtnIdxW-1:0]  cnt;
  logic [WordW-1:0]    prev_raw;
  logic [WordW-1:0]    deb;
  logic [WordW-1:0]    deb_next;
  logic [WordW-1:0]    raw;
  logic [WordW-1:0]    prior_deb;
  logic [TimeW-1:0]    now;
  logic                chg_flag;
  logic                any_flag;

  logic [ThrW-1:0]     debounce_time_ms;
  logic                debounce_enable;

  logic                in_first;
  logic [WordW-1:0]    in_shifted;
  logic [TimeW-1:0]    in_now;
  logic [WordW-1:0]    raw_in;

  logic [BitIdxW-1:0]  bit_idx;
  logic                bit_changed;
  logic [TimeW-1:0]    stored_ms;
  logic [TimeW-1:0]    last_ms;
  logic                expired;
  logic                take;
  logic                last_btn;
  scbd_wr_t            wr;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time_ms <= DebounceTimeReset;
      debounce_enable  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgDebounceTime:   debounce_time_ms <= cfg_data;
        CfgDebounceEnable: debounce_enable  <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  assign in_first   = s_tdata[0];
  assign in_shifted = s_tdata[WordW:1];
  assign in_now     = s_tdata[WordW+TimeW:WordW+1];
  assign raw_in     = {in_first, in_shifted[WordW-1:1]};

  assign s_tready = (state == ST_IDLE);

  // Button k lives at bit 15-k
  assign bit_idx     = BitIdxW'(WordW - 1) - BitIdxW'(cnt);
  assign bit_changed = raw[bit_idx] != prev_raw[bit_idx];
  assign last_btn    = (cnt == BtnIdxW'(NumButtons - 1));

  // A fresh change restarts the timer at now
  assign last_ms = bit_changed ? now : stored_ms;

  assign wr.en   = (state == ST_RUN) && bit_changed;
  assign wr.addr = cnt;
  assign wr.data = now;

  scbd_time_store u_store (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .raddr (cnt),
    .rdata (stored_ms)
  );

  scbd_elapsed_cmp u_cmp (
    .now_ms  (now),
    .last_ms (last_ms),
    .thr_ms  (debounce_time_ms),
    .expired (expired)
  );

  assign take = (state == ST_RUN) && expired && (raw[bit_idx] != deb[bit_idx]);

  always_comb begin
    deb_next = deb;
    if (take) begin
      deb_next[bit_idx] = raw[bit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      prev_raw <= '1;
      deb      <= '1;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            raw       <= raw_in;
            now       <= in_now;
            prior_deb <= deb;
            cnt       <= '0;
            if (debounce_enable) begin
              state <= ST_RUN;
            end else begin
              deb      <= raw_in;
              chg_flag <= raw_in != deb;
              any_flag <= raw_in != '1;
              m_tvalid <= 1'b1;
              state    <= ST_OUT;
            end
          end
        end
        ST_RUN: begin
          deb <= deb_next;
          if (last_btn) begin
            prev_raw <= raw;
            chg_flag <= deb_next != prior_deb;
            any_flag <= deb_next != '1;
            m_tvalid <= 1'b1;
            state    <= ST_OUT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {(OutDataW - 2*WordW - 2)'(0), any_flag, chg_flag, deb, raw};

`ifndef ASSERT_OFF
  a_one_side_open: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while a result is pending");

  a_walk_starts_clean: assert property (@(posedge clk) disable iff (rst)
    (s_tready && s_tvalid && debounce_enable) |=> (state == ST_RUN && cnt == '0))
    else $error("button walk did not start at button 1");

  a_any_matches: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[33] == (m_tdata[31:16] != 16'hFFFF)))
    else $error("any_pressed disagrees with stable word");

  a_chg_matches: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[32] == (deb != prior_deb)))
    else $error("stable_changed disagrees with stable word history");

  a_store_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == ST_RUN && !m_tvalid))
    else $error("timestamp written outside the button walk");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking stream testbench for the shift-capture button debouncer.
`timescale 1ns / 1ps

module tb_top;
  import scbd_pkg::*;

  typedef struct packed {
    logic             first_bit;
    logic [WordW-1:0] shifted_word;
    logic [TimeW-1:0] now_ms;
  } poll_t;

  typedef struct packed {
    logic [WordW-1:0] raw_buttons;
    logic [WordW-1:0] stable_buttons;
    logic             stable_changed;
    logic             any_pressed;
  } buttons_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;   // first_bit[0], shifted_word[16:1], now_ms[48:17]
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;   // raw_buttons[15:0], stable_buttons[31:16],
                                  // stable_changed[32], any_pressed[33]
  logic                cfg_we;
  logic                cfg_index;
  logic [ThrW-1:0]     cfg_data;

  shift_capture_button_debouncer_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Debouncer model state and its copy of the registers
  logic [ThrW-1:0]  hold_ms;
  logic             filter_on;
  logic [WordW-1:0] prev_raw;
  logic [WordW-1:0] stable_word;
  logic [TimeW-1:0] change_stamp [NumButtons];

  poll_t    poll_pending [$];
  poll_t    poll_on_bus;
  buttons_t button_words_due [$];
  bit       holding;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       fail_count;

  // Poll generator state
  logic [TimeW-1:0] sim_ms;
  logic [WordW-1:0] held_raw;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic buttons_t debounce_poll(poll_t p);
    buttons_t         r;
    logic [WordW-1:0] raw;
    logic [WordW-1:0] prior;
    logic [TimeW-1:0] elapsed;
    raw   = {p.first_bit, p.shifted_word[WordW-1:1]};
    prior = stable_word;
    if (!filter_on) begin
      stable_word = raw;
    end else begin
      // button k sits at bit 15-k
      for (int k = 0; k < NumButtons; k++) begin
        if (raw[WordW-1-k] != prev_raw[WordW-1-k]) change_stamp[k] = p.now_ms;
        elapsed = p.now_ms - change_stamp[k];
        if (elapsed >= {16'h0000, hold_ms} && raw[WordW-1-k] != stable_word[WordW-1-k])
          stable_word[WordW-1-k] = raw[WordW-1-k];
      end
      prev_raw = raw;
    end
    r.raw_buttons    = raw;
    r.stable_buttons = stable_word;
    r.stable_changed = (stable_word != prior);
    r.any_pressed    = (stable_word != 16'hFFFF);
    return r;
  endfunction

  // Driver: presents queued polls, holds each until its transfer
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      holding = s_tvalid;
      if (s_tvalid && s_tready) begin
        button_words_due.push_back(debounce_poll(poll_on_bus));
        holding = 1'b0;
      end
      if (!holding) begin
        if (poll_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          poll_on_bus = poll_pending.pop_front();
          s_tdata  <= {7'd0, poll_on_bus.now_ms, poll_on_bus.shifted_word,
                       poll_on_bus.first_bit};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expectation
  always @(posedge clk) begin
    buttons_t want;
    buttons_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (m_tvalid && m_tready) begin
        got.raw_buttons    = m_tdata[15:0];
        got.stable_buttons = m_tdata[31:16];
        got.stable_changed = m_tdata[32];
        got.any_pressed    = m_tdata[33];
        if (button_words_due.size() == 0) begin
          $display("%0t: unexpected result transfer %h", $time, m_tdata);
          fail_count++;
        end else begin
          want = button_words_due.pop_front();
          if (got.raw_buttons != want.raw_buttons) begin
            $display("%0t: raw_buttons expected %h actual %h", $time,
                     want.raw_buttons, got.raw_buttons);
            fail_count++;
          end
          if (got.stable_buttons != want.stable_buttons) begin
            $display("%0t: stable_buttons expected %h actual %h", $time,
                     want.stable_buttons, got.stable_buttons);
            fail_count++;
          end
          if (got.stable_changed != want.stable_changed) begin
            $display("%0t: stable_changed expected %b actual %b", $time,
                     want.stable_changed, got.stable_changed);
            fail_count++;
          end
          if (got.any_pressed != want.any_pressed) begin
            $display("%0t: any_pressed expected %b actual %b", $time,
                     want.any_pressed, got.any_pressed);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic queue_poll(input logic fb, input logic [WordW-1:0] sw,
                            input logic [TimeW-1:0] t);
    poll_t p;
    p.first_bit    = fb;
    p.shifted_word = sw;
    p.now_ms       = t;
    poll_pending.push_back(p);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (poll_pending.size() != 0 || s_tvalid || button_words_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [ThrW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CfgDebounceTime) hold_ms = val;
    else filter_on = val[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly a settling button bank with bounces; the rest are time jumps and noise
  task automatic queue_random_polls(input int count);
    int          pick;
    int unsigned span;
    logic [15:0] flips;
    span = 2 * hold_ms + 3;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        sim_ms = sim_ms + $urandom_range(0, span);
        if ($urandom_range(0, 4) == 0) begin
          flips = 16'h0001 << $urandom_range(0, 15);
          if ($urandom_range(0, 2) == 0) flips = flips | (16'h0001 << $urandom_range(0, 15));
          held_raw = held_raw ^ flips;
        end
      end else if (pick < 90) begin
        if ($urandom_range(0, 1) == 0) sim_ms = $urandom();
        else sim_ms = sim_ms - $urandom_range(1, span);
      end else begin
        sim_ms   = $urandom();
        held_raw = 16'($urandom());
      end
      queue_poll(held_raw[15], {held_raw[14:0], 1'($urandom_range(0, 1))}, sim_ms);
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    m_tready      = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CfgDebounceTime;
    cfg_data      = '0;
    fail_count    = 0;
    hold_ms       = DebounceTimeReset;
    filter_on     = 1'b1;
    prev_raw      = 16'hFFFF;
    stable_word   = 16'hFFFF;
    for (int k = 0; k < NumButtons; k++) change_stamp[k] = '0;
    sim_ms        = '0;
    held_raw      = 16'hFFFF;
    send_idle_pct = 16;
    recv_idle_pct = 63;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed polls at the reset settings
    queue_poll(1'b0, 16'hFFFF, 32'd0);           // button 1 pressed, not yet stable
    queue_poll(1'b0, 16'hFFFF, 32'd29);
    queue_poll(1'b0, 16'hFFFF, 32'd30);          // exactly the debounce time
    queue_poll(1'b0, 16'h0000, 32'd100);         // all pressed
    queue_poll(1'b0, 16'h0001, 32'd130);         // dropped low bit set
    queue_poll(1'b1, 16'hFFFF, 32'hFFFF_FFF0);   // release just before the wrap
    queue_poll(1'b1, 16'hFFFE, 32'h0000_000D);   // across the wrap, one short
    queue_poll(1'b1, 16'hFFFF, 32'h0000_000E);   // across the wrap, accepted
    queue_poll(1'b0, 16'hAAAA, 32'd1000);
    queue_poll(1'b1, 16'h5555, 32'd1005);        // bounce
    queue_poll(1'b0, 16'hAAAA, 32'd500);         // timestamp runs backwards
    queue_poll(1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    queue_poll(1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    queue_poll(1'b0, 16'h8000, 32'h8000_0000);
    queue_poll(1'b0, 16'h8000, 32'h8000_001E);
    sim_ms   = 32'h8000_001E;
    held_raw = 16'h4000;
    wait_drained();

    write_reg(CfgDebounceTime, 16'd0);
    queue_random_polls(250);
    wait_drained();
    write_reg(CfgDebounceTime, 16'hFFFF);
    queue_random_polls(250);
    wait_drained();
    write_reg(CfgDebounceEnable, 16'hFFFE);      // bypass, upper bits ignored
    queue_random_polls(250);
    wait_drained();

    send_idle_pct = 63;
    recv_idle_pct = 16;
    write_reg(CfgDebounceEnable, 16'h0003);
    write_reg(CfgDebounceTime, 16'd7);
    queue_random_polls(250);
    wait_drained();
    write_reg(CfgDebounceTime, 16'($urandom_range(2, 300)));
    queue_random_polls(250);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CfgDebounceTime, 16'd1);
    queue_random_polls(250);
    wait_drained();
    write_reg(CfgDebounceTime, 16'd30);
    queue_random_polls(250);
    wait_drained();
    repeat (40) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
